// ===== hdl/dpts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dpts_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int SLOT_W        = 3;
   localparam int PRIO_W        = 16;
   localparam int TIME_W        = 16;
   localparam int CFG_W         = 8;
   localparam int CSR_IDX_W     = 1;

   localparam logic [CFG_W-1:0]  RUN_PENALTY_RST = 8'd3;
   localparam logic [CFG_W-1:0]  AGING_STEP_RST  = 8'd1;
   localparam logic signed [PRIO_W-1:0] END_PRIORITY = -16'sd1;
   localparam logic signed [PRIO_W-1:0] PRIO_MAX     = 16'sh7fff;
   localparam logic signed [PRIO_W-1:0] PRIO_MIN     = -16'sh8000;

   localparam logic [CSR_IDX_W-1:0] CSR_RUN_PENALTY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGING_STEP  = 1'd1;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [TIME_W-1:0]        remaining;
      logic [TIME_W-1:0]        used;
   } slot_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_REPLY  = 4'b1000
   } state_type;

   function automatic logic signed [PRIO_W-1:0] sat_prio(input logic signed [PRIO_W+1:0] v);
      logic signed [PRIO_W-1:0] r;
      if (v > $signed({{2{PRIO_MAX[PRIO_W-1]}}, PRIO_MAX})) begin
         r = PRIO_MAX;
      end else if (v < $signed({{2{PRIO_MIN[PRIO_W-1]}}, PRIO_MIN})) begin
         r = PRIO_MIN;
      end else begin
         r = v[PRIO_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dynamic_priority_tick_scheduler_top.sv =====
// Dynamic priority scheduler with aging over NUM_SLOTS process slots. A load word
// (mode 0) writes one slot while the block is idle and returns nothing. A tick word
// (mode 1) returns one result word, and the input is stalled until that word has been
// registered at the output. The slot table lives in one memory with a single read
// port and a registered read. It is swept once to find the highest-priority
// unfinished slot and, if one is found, once more to charge the runner and age the
// waiting slots. Each sweep drains the read pipeline before it ends. One word is
// worked on at a time; a finished result waits in the output register while the next
// word is taken, and a tick holds in its reply state while that register is still
// stalled. Entries of slots never loaded are read by the sweeps but ignored, since
// such slots stay done, so no clearing pass follows reset.
// Configuration writes are always taken (csr_ready is tied high) and must only be
// issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module dynamic_priority_tick_scheduler_top #(
   parameter int NUM_SLOTS = dpts_pkg::NUM_SLOTS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_mode,
   input  wire logic [dpts_pkg::SLOT_W-1:0]           req_slot,
   input  wire logic signed [dpts_pkg::PRIO_W-1:0]    req_start_priority,
   input  wire logic [dpts_pkg::TIME_W-1:0]           req_burst,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_picked_valid,
   output logic [dpts_pkg::SLOT_W-1:0]                rsp_picked_slot,
   output logic                                       rsp_picked_finished,
   output logic [dpts_pkg::TIME_W-1:0]                rsp_picked_used,
   output logic                                       rsp_all_done,
   output logic [dpts_pkg::TIME_W-1:0]                rsp_tick_count,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [dpts_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [dpts_pkg::CFG_W-1:0]            csr_data
);

   localparam int AW = $clog2(NUM_SLOTS);
   localparam int XW = AW + dpts_pkg::SLOT_W;
   localparam logic [AW:0] LAST_CNT = (AW+1)'(NUM_SLOTS);

   dpts_pkg::state_type state_ff, state_in;

   dpts_pkg::slot_entry_type slot_mem_ff [NUM_SLOTS];
   dpts_pkg::slot_entry_type rd_data_ff;
   dpts_pkg::slot_entry_type mem_wd;
   logic [AW-1:0]            mem_wa;
   logic                     mem_we;
   logic [AW-1:0]            rd_addr;

   logic [NUM_SLOTS-1:0]     done_ff, done_in;
   logic [AW:0]              cnt_ff, cnt_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pend_addr_ff, pend_addr_in;
   logic                     found_ff, found_in;
   logic [AW-1:0]            best_idx_ff, best_idx_in;
   logic signed [dpts_pkg::PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic                     finished_ff, finished_in;
   logic [dpts_pkg::TIME_W-1:0] pick_used_ff, pick_used_in;
   logic [dpts_pkg::TIME_W-1:0] tick_cnt_ff, tick_cnt_in;
   logic [dpts_pkg::CFG_W-1:0]  run_penalty_ff, aging_step_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_picked_valid_ff, rsp_picked_valid_in;
   logic [dpts_pkg::SLOT_W-1:0] rsp_picked_slot_ff, rsp_picked_slot_in;
   logic                     rsp_picked_finished_ff, rsp_picked_finished_in;
   logic [dpts_pkg::TIME_W-1:0] rsp_picked_used_ff, rsp_picked_used_in;
   logic                     rsp_all_done_ff, rsp_all_done_in;
   logic [dpts_pkg::TIME_W-1:0] rsp_tick_count_ff, rsp_tick_count_in;

   logic                     issue;
   logic [XW-1:0]            ld_ext;
   logic [AW-1:0]            ld_addr;
   logic                     ld_ok;
   logic [XW-1:0]            best_ext;
   logic [dpts_pkg::TIME_W-1:0] rem_dec;
   logic [dpts_pkg::TIME_W-1:0] used_inc;
   logic signed [dpts_pkg::PRIO_W+1:0] prio_wide;
   logic signed [dpts_pkg::PRIO_W+1:0] prio_pen;
   logic signed [dpts_pkg::PRIO_W+1:0] prio_age;

   assign req_stall = (state_ff != dpts_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_picked_valid    = rsp_picked_valid_ff;
   assign rsp_picked_slot     = rsp_picked_slot_ff;
   assign rsp_picked_finished = rsp_picked_finished_ff;
   assign rsp_picked_used     = rsp_picked_used_ff;
   assign rsp_all_done        = rsp_all_done_ff;
   assign rsp_tick_count      = rsp_tick_count_ff;

   assign issue    = (cnt_ff < LAST_CNT);
   assign rd_addr  = cnt_ff[AW-1:0];
   assign ld_ext   = XW'(req_slot);
   assign ld_addr  = ld_ext[AW-1:0];
   assign ld_ok    = (32'(req_slot) < NUM_SLOTS);
   assign best_ext = XW'(best_idx_ff);
   assign rem_dec  = rd_data_ff.remaining - 1'b1;
   assign used_inc = rd_data_ff.used + 1'b1;
   assign prio_wide = $signed({{2{rd_data_ff.prio[dpts_pkg::PRIO_W-1]}}, rd_data_ff.prio});
   assign prio_pen  = prio_wide - $signed({10'b0, run_penalty_ff});
   assign prio_age  = prio_wide + $signed({10'b0, aging_step_ff});

   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_addr_in = rd_addr;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      finished_in  = finished_ff;
      pick_used_in = pick_used_ff;
      tick_cnt_in  = tick_cnt_ff;
      mem_we       = 1'b0;
      mem_wa       = pend_addr_ff;
      mem_wd       = rd_data_ff;
      rsp_valid_in           = rsp_valid_ff & rsp_stall;
      rsp_picked_valid_in    = rsp_picked_valid_ff;
      rsp_picked_slot_in     = rsp_picked_slot_ff;
      rsp_picked_finished_in = rsp_picked_finished_ff;
      rsp_picked_used_in     = rsp_picked_used_ff;
      rsp_all_done_in        = rsp_all_done_ff;
      rsp_tick_count_in      = rsp_tick_count_ff;

      unique case (state_ff)
         dpts_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == dpts_pkg::MODE_LOAD) begin
                  if (ld_ok) begin
                     mem_we           = 1'b1;
                     mem_wa           = ld_addr;
                     mem_wd.prio      = req_start_priority;
                     mem_wd.remaining = req_burst;
                     mem_wd.used      = '0;
                     done_in[ld_addr] = (req_burst == '0);
                  end
               end else begin
                  tick_cnt_in = tick_cnt_ff + 1'b1;
                  cnt_in      = '0;
                  found_in    = 1'b0;
                  finished_in = 1'b0;
                  state_in    = dpts_pkg::ST_SCAN;
               end
            end
         end
         dpts_pkg::ST_SCAN: begin
            if (issue) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
            if (pend_ff && !done_ff[pend_addr_ff] &&
                (!found_ff || (rd_data_ff.prio > best_prio_ff))) begin
               found_in     = 1'b1;
               best_idx_in  = pend_addr_ff;
               best_prio_in = rd_data_ff.prio;
            end
            if (!issue && !pend_ff) begin
               cnt_in   = '0;
               state_in = found_ff ? dpts_pkg::ST_UPDATE : dpts_pkg::ST_REPLY;
            end
         end
         dpts_pkg::ST_UPDATE: begin
            if (issue) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
            if (pend_ff && !done_ff[pend_addr_ff]) begin
               mem_we = 1'b1;
               if (pend_addr_ff == best_idx_ff) begin
                  mem_wd.used      = used_inc;
                  mem_wd.remaining = rem_dec;
                  pick_used_in     = used_inc;
                  if (rem_dec != '0) begin
                     mem_wd.prio = dpts_pkg::sat_prio(prio_pen);
                  end else begin
                     mem_wd.prio           = dpts_pkg::END_PRIORITY;
                     done_in[pend_addr_ff] = 1'b1;
                     finished_in           = 1'b1;
                  end
               end else begin
                  mem_wd.prio = dpts_pkg::sat_prio(prio_age);
               end
            end
            if (!issue && !pend_ff) begin
               state_in = dpts_pkg::ST_REPLY;
            end
         end
         dpts_pkg::ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_picked_valid_in    = found_ff;
               rsp_picked_slot_in     = found_ff ? best_ext[dpts_pkg::SLOT_W-1:0] : '0;
               rsp_picked_finished_in = finished_ff;
               rsp_picked_used_in     = found_ff ? pick_used_ff : '0;
               rsp_all_done_in        = &done_ff;
               rsp_tick_count_in      = tick_cnt_ff;
               state_in               = dpts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dpts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dpts_pkg::ST_IDLE;
         done_ff        <= '1;
         cnt_ff         <= '0;
         pend_ff        <= 1'b0;
         found_ff       <= 1'b0;
         finished_ff    <= 1'b0;
         tick_cnt_ff    <= '0;
         run_penalty_ff <= dpts_pkg::RUN_PENALTY_RST;
         aging_step_ff  <= dpts_pkg::AGING_STEP_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         finished_ff  <= finished_in;
         tick_cnt_ff  <= tick_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               dpts_pkg::CSR_RUN_PENALTY: run_penalty_ff <= csr_data;
               dpts_pkg::CSR_AGING_STEP:  aging_step_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff           <= pend_addr_in;
      best_idx_ff            <= best_idx_in;
      best_prio_ff           <= best_prio_in;
      pick_used_ff           <= pick_used_in;
      rsp_picked_valid_ff    <= rsp_picked_valid_in;
      rsp_picked_slot_ff     <= rsp_picked_slot_in;
      rsp_picked_finished_ff <= rsp_picked_finished_in;
      rsp_picked_used_ff     <= rsp_picked_used_in;
      rsp_all_done_ff        <= rsp_all_done_in;
      rsp_tick_count_ff      <= rsp_tick_count_in;
   end

`ifndef SYNTH
   a_pend_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == dpts_pkg::ST_SCAN || state_ff == dpts_pkg::ST_UPDATE))
      else $error("read pending outside a sweep");

   a_update_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dpts_pkg::ST_UPDATE) |-> found_ff)
      else $error("update sweep without a picked slot");

   a_finish_marks_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dpts_pkg::ST_REPLY && finished_ff) |-> done_ff[best_idx_ff])
      else $error("finished slot not marked done");

   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == dpts_pkg::ST_REPLY))
      else $error("result word raised outside reply");

   a_idle_tick_all_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_picked_valid_ff) |-> rsp_all_done_ff)
      else $error("idle tick with unfinished slots");
`endif

endmodule

`default_nettype wire
